// ===== rtl/mexp_pkg.sv =====
// shared types and constants for the modular exponentiation unit
package mexp_pkg;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MODULUS  = 1'b0,
    CFG_EXPONENT = 1'b1
  } cfg_idx_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_CHK,
    S_MULP,
    S_SQR,
    S_FIN
  } state_t;

  // multiplicand source when a modular product starts
  typedef enum logic {
    MS_PROD,
    MS_SQUARE
  } mul_src_t;

  // where a finished modular product is written
  typedef enum logic {
    MD_BASE,
    MD_POWER
  } mul_dst_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_src_t mul_src;
    logic     mul_step;
    logic     mul_end;
    mul_dst_t mul_dst;
    logic     e_shift;
    logic     out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic y_zero;
    logic e_lsb;
    logic e_rest_zero;
    logic spec;
  } dp_stat_t;

endpackage

// ===== rtl/mexp_datapath.sv =====
// datapath: config registers, exponent shifter and shift-and-add modular multiplier
module mexp_datapath #(
  parameter int unsigned W = 31
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [mexp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [W-1:0]                           cfg_wdata,
  input  logic [W-1:0]                           in_base_value,
  input  mexp_pkg::dp_cmd_t                      cmd,
  output mexp_pkg::dp_stat_t                     stat,
  output logic [W-1:0]                           out_power_result
);
  import mexp_pkg::*;

  logic [W-1:0] mod_r;
  logic [W-1:0] exp_r;
  logic [W-1:0] e_r;
  logic [W-1:0] b_r;
  logic [W-1:0] p_r;
  logic [W-1:0] a_r;
  logic [W-1:0] x_r;
  logic [W-1:0] y_r;
  logic [W-1:0] out_r;

  logic [W-1:0] one_mod;
  logic [W-1:0] p_init;
  logic [W:0]   mod_ext;
  logic [W:0]   sum_a;
  logic [W:0]   sum_x;
  logic [W:0]   red_a;
  logic [W:0]   red_x;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= W'(1);
      exp_r <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_MODULUS) begin
        mod_r <= cfg_wdata;
      end else if (cfg_index == CFG_EXPONENT) begin
        exp_r <= cfg_wdata;
      end
    end
  end

  // one reduced by the modulus, and the starting power value
  assign one_mod = (mod_r == W'(1)) ? '0 : W'(1);
  assign p_init  = (exp_r == '0) ? W'(1) : ((mod_r == '0) ? '0 : one_mod);

  // add and reduce: both operands stay below the modulus, one subtract suffices
  assign mod_ext = {1'b0, mod_r};
  assign sum_a   = {1'b0, a_r} + {1'b0, x_r};
  assign sum_x   = {x_r, 1'b0};
  assign red_a   = (sum_a >= mod_ext) ? (sum_a - mod_ext) : sum_a;
  assign red_x   = (sum_x >= mod_ext) ? (sum_x - mod_ext) : sum_x;

  // multiplier registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= '0;
      x_r <= one_mod;
      y_r <= in_base_value;
    end else if (cmd.mul_start) begin
      a_r <= '0;
      x_r <= (cmd.mul_src == MS_PROD) ? p_r : b_r;
      y_r <= b_r;
    end else if (cmd.mul_step) begin
      if (y_r[0]) begin
        a_r <= red_a[W-1:0];
      end
      x_r <= red_x[W-1:0];
      y_r <= {1'b0, y_r[W-1:1]};
    end
  end

  // base, running power and exponent bits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r <= p_init;
      e_r <= exp_r;
    end else begin
      if (cmd.mul_end && cmd.mul_dst == MD_POWER) begin
        p_r <= a_r;
      end
      if (cmd.e_shift) begin
        e_r <= {1'b0, e_r[W-1:1]};
      end
    end
    if (cmd.mul_end && cmd.mul_dst == MD_BASE) begin
      b_r <= a_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= p_r;
    end
  end

  assign out_power_result = out_r;

  // status to the controller
  assign stat.y_zero      = (y_r == '0);
  assign stat.e_lsb       = e_r[0];
  assign stat.e_rest_zero = (e_r[W-1:1] == '0);
  assign stat.spec        = (exp_r == '0) || (mod_r == '0);

  // partial products stay reduced while the multiplier runs
  a_step_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_step |-> (a_r < mod_r) && (x_r < mod_r))
    else $error("multiplier operand not reduced");

  // a product is only taken once its multiplier is used up
  a_end_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_end |-> (y_r == '0))
    else $error("product taken before multiplier exhausted");

  // a computed power is fully reduced when it goes to the result register
  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && !stat.spec) |-> (p_r < mod_r))
    else $error("result not reduced by the modulus");

endmodule

// ===== rtl/mexp_ctrl.sv =====
// controller: sequences base reduction, products and squarings per exponent bit
module mexp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  mexp_pkg::dp_stat_t stat,
  output mexp_pkg::dp_cmd_t  cmd
);
  import mexp_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.spec ? S_FIN : S_RED;
        end
      end
      S_RED: begin
        if (stat.y_zero) begin
          cmd.mul_end = 1'b1;
          cmd.mul_dst = MD_BASE;
          state_nxt   = S_CHK;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_CHK: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = stat.e_lsb ? MS_PROD : MS_SQUARE;
        state_nxt     = stat.e_lsb ? S_MULP : S_SQR;
      end
      S_MULP: begin
        if (stat.y_zero) begin
          cmd.mul_end = 1'b1;
          cmd.mul_dst = MD_POWER;
          if (stat.e_rest_zero) begin
            state_nxt = S_FIN;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.mul_src   = MS_SQUARE;
            state_nxt     = S_SQR;
          end
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_SQR: begin
        if (stat.y_zero) begin
          cmd.mul_end = 1'b1;
          cmd.mul_dst = MD_BASE;
          cmd.e_shift = 1'b1;
          state_nxt   = S_CHK;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register holds until the receiver takes it
  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);
  assign out_valid     = out_valid_r;
  assign in_stall      = (state_r != S_IDLE);

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // the multiplier never steps past an exhausted multiplier
  a_no_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_step |-> !stat.y_zero)
    else $error("multiplier stepped with nothing left");

  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("request accepted without starting work");

endmodule

// ===== rtl/modular_exponentiation_unit.sv =====
// top level of the modular exponentiation unit
// Computes power_result = base_value ^ exponent mod modulus for each request.
// Configuration: cfg_wr_en with cfg_index 0 writes the modulus, index 1 the
// exponent; write only while no request is in flight. Reset gives modulus 1
// and exponent 0. An exponent of 0 answers 1; a modulus of 0 answers 0.
// Input channel: a request is taken when in_valid is high and in_stall low.
// in_stall is low only while the unit is idle, so one request is worked on
// at a time. Work per request: the multiplier first reduces the base; then per
// exponent bit come one check, one squaring and, for a set bit, one product,
// each made of add-and-reduce steps, one per significant bit of the multiplier,
// and a final write-back; the top bit skips its squaring. The shift-and-add
// multiplier loop sets the pace. The next request is taken only once the unit
// is back in idle; a zero exponent or zero modulus skips the arithmetic and
// goes straight to the result register.
// Output channel: the result sits in a register with out_valid high until
// out_stall is low. A new request is accepted while a result still waits;
// its own result is held back until the register is taken.
// Reset is synchronous and active low; it drops any request in flight.
module modular_exponentiation_unit #(
  parameter int unsigned OPERAND_BITS = 31
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [mexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [OPERAND_BITS-1:0]             cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [OPERAND_BITS-1:0]             in_base_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [OPERAND_BITS-1:0]             out_power_result
);
  import mexp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and storage
  mexp_datapath #(
    .W (OPERAND_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_base_value    (in_base_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_power_result (out_power_result)
  );

endmodule

// ===== sim/tb_top.sv =====
// testbench for the modular exponentiation unit: directed and random requests, self-checking
`timescale 1ns / 100ps

module tb_top;
  import mexp_pkg::*;

  localparam int OPB = 31;
  localparam bit [OPB-1:0] OPERAND_MAX = '1;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 50;
  localparam int REPORT_LIMIT = 10;

  logic           clk;
  logic           rst_n;
  logic           cfg_wr_en;
  cfg_idx_t       cfg_index;
  logic [OPB-1:0] cfg_wdata;
  logic           in_valid;
  logic           in_stall;
  logic [OPB-1:0] in_base_value;
  logic           out_valid;
  logic           out_stall;
  logic [OPB-1:0] out_power_result;

  // local copy of the unit's configuration
  bit [OPB-1:0] cur_modulus;
  bit [OPB-1:0] cur_exponent;

  bit [OPB-1:0] pending_powers[$];
  logic [OPB-1:0] want_power;
  int mismatches;
  int idle_cycles;
  int stall_left;
  bit idling_on;

  modular_exponentiation_unit #(
    .OPERAND_BITS(OPB)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_base_value    (in_base_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_result (out_power_result)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // base ^ exponent mod modulus by right-to-left square-and-multiply
  function automatic bit [OPB-1:0] predict_power(input bit [OPB-1:0] base_value);
    bit [63:0] acc;
    bit [63:0] sq;
    bit [OPB-1:0] bits_left;
    if (cur_exponent == 0) return 1;
    if (cur_modulus == 0) return 0;
    acc = 1;
    sq = 64'(base_value % cur_modulus);
    bits_left = cur_exponent;
    while (bits_left != 0) begin
      if (bits_left[0]) acc = (acc * sq) % cur_modulus;
      sq = (sq * sq) % cur_modulus;
      bits_left = bits_left >> 1;
    end
    return acc[OPB-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [OPB-1:0] want,
                                 input logic [OPB-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch (%s) at %0t: expected %0d, got %0d", what, $time, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_powers.size() == 0) begin
        report_mismatch("no request pending", 'x, out_power_result);
      end else begin
        want_power = pending_powers.pop_front();
        if (out_power_result !== want_power) begin
          report_mismatch("power_result", want_power, out_power_result);
        end
      end
    end
  end

  // receiver back-pressure in short bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall = 1'b0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // send one request; entered and left at a falling edge
  task automatic send_base(input bit [OPB-1:0] base_value);
    int gap;
    if (idling_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_base_value = base_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_powers.push_back(predict_power(base_value));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // hold off until every expected result has come back
  task automatic wait_results(input int extra);
    while (pending_powers.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input bit [OPB-1:0] value);
    wait_results(SETTLE_CYCLES);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == CFG_MODULUS) cur_modulus = value;
    else cur_exponent = value;
  endtask

  task automatic set_config(input bit [OPB-1:0] modulus, input bit [OPB-1:0] exponent);
    write_reg(CFG_MODULUS, modulus);
    write_reg(CFG_EXPONENT, exponent);
  endtask

  function automatic bit [OPB-1:0] pick_modulus();
    case ($urandom_range(0, 7))
      0: return 1;
      1: return 2;
      2: return OPERAND_MAX;
      3: return OPB'($urandom_range(3, 1000));
      4: return OPB'(1) << (OPB - 1);
      default: return OPB'($urandom_range(1, OPERAND_MAX));
    endcase
  endfunction

  // mostly short exponents to keep the run time down, a few full width
  function automatic bit [OPB-1:0] pick_exponent();
    int w;
    w = $urandom_range(1, 10);
    case ($urandom_range(0, 9))
      0: return OPERAND_MAX;
      1: return OPB'($urandom());
      2: return 0;
      default: return OPB'($urandom_range(1 << (w - 1), (1 << w) - 1));
    endcase
  endfunction

  function automatic bit [OPB-1:0] pick_base();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return OPERAND_MAX;
      3: return cur_modulus - OPB'(1);
      4: return cur_modulus;
      5: return cur_modulus + OPB'($urandom_range(1, 100));
      default: return OPB'($urandom());
    endcase
  endfunction

  // reset values: modulus 1, exponent 0, so every base answers 1
  task automatic test_reset_state();
    send_base(0);
    send_base(OPERAND_MAX);
    send_base(12345);
  endtask

  // zero exponent answers 1, also for modulus 1
  task automatic test_zero_exponent();
    set_config(OPERAND_MAX, 0);
    send_base(0);
    send_base(OPERAND_MAX);
    set_config(1, 0);
    send_base(7);
  endtask

  // zero modulus: 0 for a nonzero exponent, 1 for a zero exponent
  task automatic test_zero_modulus();
    set_config(0, 5);
    send_base(9);
    send_base(0);
    write_reg(CFG_EXPONENT, 0);
    send_base(3);
  endtask

  // full-width operands, base at or above the modulus, tiny moduli
  task automatic test_operand_extremes();
    set_config(OPERAND_MAX, OPERAND_MAX);
    send_base(0);
    send_base(1);
    send_base(OPERAND_MAX - 1);
    send_base(OPERAND_MAX);
    send_base(2);
    set_config(1, 3);
    send_base(OPERAND_MAX);
    set_config(2, 1);
    send_base(OPERAND_MAX);
    set_config(13, 2);
    send_base(30);
    send_base(13);
    set_config(OPB'(1) << (OPB - 1), OPERAND_MAX);
    send_base(3);
  endtask

  // random settings, each followed by a batch of random bases
  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      set_config(pick_modulus(), pick_exponent());
      idling_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 30; n++) send_base(pick_base());
    end
    idling_on = 1'b1;
  endtask

  // sender waits for the unit to drain between short groups
  task automatic test_drain_pause();
    set_config(pick_modulus(), pick_exponent());
    for (int n = 0; n < 12; n++) begin
      send_base(pick_base());
      if (n % 4 == 3) wait_results(0);
    end
  endtask

  // last stretch without any idling on either side
  task automatic test_quiet_tail();
    idling_on = 1'b0;
    set_config(pick_modulus(), pick_exponent());
    for (int n = 0; n < 20; n++) send_base(pick_base());
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_MODULUS;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_base_value = '0;
    out_stall = 1'b0;
    stall_left = 0;
    idling_on = 1'b1;
    mismatches = 0;
    idle_cycles = 0;
    cur_modulus = 1;
    cur_exponent = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_state();
    test_zero_exponent();
    test_zero_modulus();
    test_operand_extremes();
    test_random_settings();
    test_drain_pause();
    test_quiet_tail();

    wait_results(DRAIN_CYCLES);
    if (mismatches == 0 && pending_powers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
